### rtl/core/exps_pkg.sv
// Shared types, constants and field layout for the exponential search engine.
package exps_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 10;
    localparam int CNT_W  = 11;
    localparam int BND_W  = 12;
    localparam int POS_W  = 13;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    // Input word layout inside s_tdata, lowest bit first.
    localparam int ADDR_LSB = 0;
    localparam int VAL_LSB  = ADDR_LSB + ADDR_W;
    localparam int KEY_LSB  = VAL_LSB + DATA_W;
    localparam int IN_USED  = KEY_LSB + DATA_W;

    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_ELEMENT_COUNT = '0;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef logic        [CNT_W-1:0]  cnt_t;
    typedef logic        [BND_W-1:0]  bnd_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [DATA_W-1:0] val_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DOUBLE,
        ST_BINARY,
        ST_DONE
    } state_t;

    // Table port request from the sequencer.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] waddr;
        val_t              wdata;
        bnd_t              raddr;
    } tbl_req_t;

endpackage

### rtl/core/exps_table.sv
// Sorted value table: one write port and one read port with registered read data.
module exps_table #(
    parameter int TABLE_DEPTH = exps_pkg::TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  exps_pkg::tbl_req_t req,
    output exps_pkg::val_t     rdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int XW = (AW > exps_pkg::BND_W) ? AW : exps_pkg::BND_W;

    exps_pkg::val_t mem [TABLE_DEPTH];
    exps_pkg::val_t rdata_reg;

    logic [XW-1:0] wide_waddr;
    logic [XW-1:0] wide_raddr;
    logic [AW-1:0] widx;
    logic [AW-1:0] ridx;

    assign wide_waddr = XW'(req.waddr);
    assign wide_raddr = XW'(req.raddr);
    assign widx       = wide_waddr[AW-1:0];
    assign ridx       = wide_raddr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[widx] <= req.wdata;
        end
        rdata_reg <= mem[ridx];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/exps_ctrl.sv
// Search sequencer: doubling and binary probe phases around one shared comparator.
module exps_ctrl #(
    parameter int TABLE_DEPTH = exps_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  exps_pkg::cnt_t                    element_count,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [exps_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [exps_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,
    output exps_pkg::tbl_req_t                tbl_req,
    input  exps_pkg::val_t                    tbl_rdata
);

    exps_pkg::state_t state_reg, state_next;

    exps_pkg::val_t key_reg, key_next;
    exps_pkg::cnt_t n_reg, n_next;
    exps_pkg::bnd_t bound_reg, bound_next;
    exps_pkg::pos_t lo_reg, lo_next;
    exps_pkg::pos_t hi_reg, hi_next;
    exps_pkg::pos_t mid_reg, mid_next;
    logic           found_reg, found_next;
    logic [exps_pkg::ADDR_W-1:0] idx_reg, idx_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        out_found_reg, out_found_next;
    logic [exps_pkg::ADDR_W-1:0] out_idx_reg, out_idx_next;

    logic           take;
    logic           is_search;
    logic           out_free;
    exps_pkg::cnt_t n_in;
    exps_pkg::cnt_t n_cur;
    exps_pkg::val_t in_key;
    logic [exps_pkg::ADDR_W-1:0] in_addr;

    // Shared comparator: probed entry against the key.
    logic key_eq;
    logic key_lt;
    logic probe_lt;

    exps_pkg::bnd_t bound_dbl;
    logic           dbl_cont;
    exps_pkg::bnd_t entry_bound;
    exps_pkg::bnd_t last_idx;
    exps_pkg::pos_t lo0;
    exps_pkg::pos_t top0;
    exps_pkg::pos_t mid0;
    exps_pkg::pos_t lo_n;
    exps_pkg::pos_t hi_n;
    exps_pkg::pos_t sum_n;
    exps_pkg::pos_t sum0;
    exps_pkg::pos_t mid_n;
    logic           bin_cont;

    assign take      = s_tvalid && s_tready;
    assign is_search = (s_tuser == exps_pkg::FUNC_SEARCH);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_key    = s_tdata[exps_pkg::KEY_LSB +: exps_pkg::DATA_W];
    assign in_addr   = s_tdata[exps_pkg::ADDR_LSB +: exps_pkg::ADDR_W];

    assign n_in  = (32'(element_count) > 32'(TABLE_DEPTH)) ?
                   exps_pkg::cnt_t'(TABLE_DEPTH) : element_count;
    assign n_cur = (state_reg == exps_pkg::ST_IDLE) ? n_in : n_reg;

    assign key_eq   = (tbl_rdata == key_reg);
    assign key_lt   = (key_reg < tbl_rdata);
    assign probe_lt = !key_eq && !key_lt;

    // Doubling phase.
    assign bound_dbl = {bound_reg[exps_pkg::BND_W-2:0], 1'b0};
    assign dbl_cont  = probe_lt && (bound_dbl < exps_pkg::bnd_t'(n_reg));

    // Range handed to the binary phase once doubling stops.
    always_comb
    begin
        if (state_reg == exps_pkg::ST_IDLE)
        begin
            entry_bound = exps_pkg::bnd_t'(1);
        end
        else if (probe_lt)
        begin
            entry_bound = bound_dbl;
        end
        else
        begin
            entry_bound = bound_reg;
        end
    end

    assign last_idx = exps_pkg::bnd_t'(n_cur) - exps_pkg::bnd_t'(1);
    assign lo0      = exps_pkg::pos_t'(entry_bound >> 1);
    assign top0     = (entry_bound < last_idx) ? exps_pkg::pos_t'(entry_bound)
                                               : exps_pkg::pos_t'(last_idx);
    assign sum0     = lo0 + top0;
    assign mid0     = exps_pkg::pos_t'(sum0[exps_pkg::POS_W-1:1]);

    // Binary phase: narrow the range around the probed midpoint.
    assign lo_n     = key_lt ? lo_reg : (mid_reg + exps_pkg::pos_t'(1));
    assign hi_n     = key_lt ? (mid_reg - exps_pkg::pos_t'(1)) : hi_reg;
    assign bin_cont = (lo_n <= hi_n);
    assign sum_n    = lo_n + hi_n;
    assign mid_n    = exps_pkg::pos_t'(sum_n[exps_pkg::POS_W-1:1]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            exps_pkg::ST_IDLE:
            begin
                if (take && is_search)
                begin
                    if (n_in == '0)
                    begin
                        state_next = exps_pkg::ST_DONE;
                    end
                    else if (n_in > exps_pkg::cnt_t'(1))
                    begin
                        state_next = exps_pkg::ST_DOUBLE;
                    end
                    else
                    begin
                        state_next = exps_pkg::ST_BINARY;
                    end
                end
            end
            exps_pkg::ST_DOUBLE:
            begin
                if (!dbl_cont)
                begin
                    state_next = exps_pkg::ST_BINARY;
                end
            end
            exps_pkg::ST_BINARY:
            begin
                if (key_eq || !bin_cont)
                begin
                    state_next = exps_pkg::ST_DONE;
                end
            end
            exps_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = exps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = exps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        key_next       = key_reg;
        n_next         = n_reg;
        bound_next     = bound_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        out_found_next = out_found_reg;
        out_idx_next   = out_idx_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        case (state_reg)
            exps_pkg::ST_IDLE:
            begin
                if (take && is_search)
                begin
                    key_next   = in_key;
                    n_next     = n_in;
                    bound_next = exps_pkg::bnd_t'(1);
                    lo_next    = lo0;
                    hi_next    = top0;
                    mid_next   = mid0;
                    found_next = 1'b0;
                    idx_next   = '0;
                end
            end
            exps_pkg::ST_DOUBLE:
            begin
                if (dbl_cont)
                begin
                    bound_next = bound_dbl;
                end
                else
                begin
                    lo_next  = lo0;
                    hi_next  = top0;
                    mid_next = mid0;
                end
            end
            exps_pkg::ST_BINARY:
            begin
                lo_next  = lo_n;
                hi_next  = hi_n;
                mid_next = mid_n;
                if (key_eq)
                begin
                    found_next = 1'b1;
                    idx_next   = mid_reg[exps_pkg::ADDR_W-1:0];
                end
            end
            exps_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    out_found_next = found_reg;
                    out_idx_next   = idx_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        s_tready            = (state_reg == exps_pkg::ST_IDLE);
        tbl_req.wr_en       = (state_reg == exps_pkg::ST_IDLE) && take && !is_search &&
                              (32'(in_addr) < 32'(TABLE_DEPTH));
        tbl_req.waddr       = in_addr;
        tbl_req.wdata       = s_tdata[exps_pkg::VAL_LSB +: exps_pkg::DATA_W];
        tbl_req.raddr       = mid0[exps_pkg::BND_W-1:0];
        unique case (state_reg)
            exps_pkg::ST_IDLE:
            begin
                if (n_in > exps_pkg::cnt_t'(1))
                begin
                    tbl_req.raddr = exps_pkg::bnd_t'(1);
                end
            end
            exps_pkg::ST_DOUBLE:
            begin
                if (dbl_cont)
                begin
                    tbl_req.raddr = bound_dbl;
                end
            end
            exps_pkg::ST_BINARY:
            begin
                tbl_req.raddr = mid_n[exps_pkg::BND_W-1:0];
            end
            exps_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= exps_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        n_reg         <= n_next;
        bound_reg     <= bound_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        found_reg     <= found_next;
        idx_reg       <= idx_next;
        out_found_reg <= out_found_next;
        out_idx_reg   <= out_idx_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = exps_pkg::M_TDATA_W'(out_idx_reg);

endmodule

### rtl/core/exponential_search_engine.sv
// Operation: a table write is taken while the block is idle; a search holds the block
// through its doubling and binary probe phases, which an empty table skips, with one
// table read per probe cycle; its result is valid in the cycle the next word can be taken.
// Throughput: one word at a time; a full output register holds the search until it drains.
// Reset: rst_n clears the sequencer, the output valid and element_count; table contents
// stay undefined until written.
module exponential_search_engine #(
    parameter int TABLE_DEPTH = exps_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [exps_pkg::APB_AW-1:0]       paddr,
    input  logic [exps_pkg::APB_DW-1:0]       pwdata,
    output logic [exps_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: entry_address[9:0], entry_value[41:10], search_key[73:42], zero pad
    input  logic [exps_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: func[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: found_index[9:0], zero pad
    output logic [exps_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: found[0]
    output logic                              m_tuser
);

    exps_pkg::cnt_t count_reg;
    exps_pkg::cnt_t count_next;

    logic                              reg_wr;
    logic [exps_pkg::REG_IDX_W-1:0]    reg_idx;

    exps_pkg::tbl_req_t tbl_req;
    exps_pkg::val_t     tbl_rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[exps_pkg::APB_AW-1:2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        count_next = count_reg;
        if (reg_wr && (reg_idx == exps_pkg::REG_ELEMENT_COUNT))
        begin
            count_next = pwdata[exps_pkg::CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == exps_pkg::REG_ELEMENT_COUNT)
        begin
            prdata = exps_pkg::APB_DW'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    exps_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_count (count_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .tbl_req       (tbl_req),
        .tbl_rdata     (tbl_rdata)
    );

    exps_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

endmodule
